FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the timer conversion block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk and ignored during reset.
`define TTC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define TTC_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ttc_pkg.sv
// ---------------------------------------------------------------------------
// Timer conversion package
// Widths, unit constants and item codes shared by the conversion block.
// ---------------------------------------------------------------------------
package ttc_pkg;

	// Field and state widths.
	localparam int COUNT_W  = 64;
	localparam int FREQ_W   = 32;
	localparam int MS_NUM_W = 10;
	localparam int NS_NUM_W = 30;

	// Serial unit lengths.
	localparam int DIV_STEPS = COUNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int MUL_STEPS = NS_NUM_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
	localparam int SHIFT_W   = 4;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [FREQ_W-1:0]  freq_t;

	// Units per second.
	localparam freq_t MS_PER_SEC = freq_t'(1000);
	localparam freq_t NS_PER_SEC = freq_t'(1000000000);

	// Frequency after reset.
	localparam freq_t FREQ_RESET = freq_t'(1000000);

	// Item kinds.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_START   = 2'd0;
	localparam kind_t KIND_READ_MS = 2'd1;
	localparam kind_t KIND_READ_NS = 2'd2;
	localparam kind_t KIND_STOP    = 2'd3;

endpackage

FILE: rtl/ttc_gcd.sv
// ---------------------------------------------------------------------------
// Binary GCD unit
// Greatest common divisor by shift and subtract, one step per cycle.
// ---------------------------------------------------------------------------
module ttc_gcd import ttc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  freq_t a_in,
	input  freq_t b_in,
	output logic  done,
	output freq_t gcd
);

	logic               busy_q;
	logic               done_q;
	freq_t              a_q;
	freq_t              b_q;
	freq_t              g_q;
	logic [SHIFT_W-1:0] k_q;

	// Control: busy until the second operand reaches zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: strip common twos, then reduce the odd parts by subtraction.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (b_q == '0) begin
				g_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	assign done = done_q;
	assign gcd  = g_q;

endmodule

FILE: rtl/ttc_mul.sv
// ---------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product of the tick count and a numerator, one bit per cycle.
// ---------------------------------------------------------------------------
module ttc_mul import ttc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  count_t              multiplicand,
	input  logic [NS_NUM_W-1:0] multiplier,
	output logic                done,
	output count_t              product,
	output logic                overflow
);

	logic                        busy_q;
	logic                        done_q;
	logic [MUL_CNT_W-1:0]        cnt_q;
	count_t                      mcand_q;
	logic [NS_NUM_W-1:0]         mpr_q;
	logic [COUNT_W+NS_NUM_W-1:0] acc_q;

	// Control: count the multiplier bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: most significant multiplier bit first, full-width accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= multiplicand;
			mpr_q   <= multiplier;
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[COUNT_W+NS_NUM_W-2:0], 1'b0}
				+ (mpr_q[NS_NUM_W-1] ? {{NS_NUM_W{1'b0}}, mcand_q} : '0);
			mpr_q <= {mpr_q[NS_NUM_W-2:0], 1'b0};
		end
	end

	assign done     = done_q;
	assign product  = acc_q[COUNT_W-1:0];
	assign overflow = |acc_q[COUNT_W+NS_NUM_W-1:COUNT_W];

endmodule

FILE: rtl/ttc_div.sv
// ---------------------------------------------------------------------------
// Serial divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. A zero divisor yields a quotient of all ones.
// ---------------------------------------------------------------------------
module ttc_div import ttc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  count_t dividend,
	input  freq_t  divisor,
	output logic   done,
	output count_t quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	count_t               quo_q;
	freq_t                rem_q;
	freq_t                dsr_q;
	logic [FREQ_W:0]      trial;
	logic [FREQ_W:0]      diff;
	logic                 fits;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, quo_q[COUNT_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Control: count the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[COUNT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/timer_tick_to_time_converter_core.sv
// A read on a started timer runs the serial multiplier and then the serial
// divider. A start, or a read that starts the timer, first adds two GCD runs
// and four divides. Stop and a repeated start go straight to the output
// state. One item is in flight at a time.
// Reset is asynchronous: not started, frequency 1000000 ticks per second.
// ---------------------------------------------------------------------------
// Timer tick to time converter
// Turns a free-running 64-bit timer count into milliseconds or nanoseconds
// elapsed since a captured start, using shared serial GCD, multiply and
// divide units under a small sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_tick_to_time_converter_core import ttc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  freq_t  cfg_wdata,
	input  logic   in_valid,
	output logic   in_stall,
	input  kind_t  kind,
	input  count_t counter_value,
	output logic   out_valid,
	input  logic   out_stall,
	output count_t elapsed_time,
	output logic   product_overflow
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_GCD_MS = 4'd1;
	localparam logic [3:0] S_NUM_MS = 4'd2;
	localparam logic [3:0] S_DEN_MS = 4'd3;
	localparam logic [3:0] S_GCD_NS = 4'd4;
	localparam logic [3:0] S_NUM_NS = 4'd5;
	localparam logic [3:0] S_DEN_NS = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]          state_q;
	logic                launch_q;
	freq_t               freq_q;
	count_t              start_q;
	logic [MS_NUM_W-1:0] ms_num_q;
	freq_t               ms_den_q;
	logic [NS_NUM_W-1:0] ns_num_q;
	freq_t               ns_den_q;
	kind_t               kind_q;
	count_t              count_q;
	count_t              res_time_q;
	logic                res_ovf_q;
	logic                out_valid_q;
	count_t              out_time_q;
	logic                out_ovf_q;

	logic                accept;
	logic                out_free;
	logic                is_ms;
	freq_t               gcd_a;
	logic                gcd_done;
	freq_t               gcd_res;
	count_t              div_dividend;
	freq_t               div_divisor;
	logic                div_done;
	count_t              div_quo;
	logic [NS_NUM_W-1:0] mul_num;
	count_t              ticks;
	logic                mul_done;
	count_t              mul_prod;
	logic                mul_ovf;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign is_ms    = (kind_q == KIND_READ_MS);

	// Operand selection for the shared units.
	assign gcd_a   = (state_q == S_GCD_MS) ? MS_PER_SEC : NS_PER_SEC;
	assign ticks   = count_q - start_q;
	assign mul_num = is_ms ? NS_NUM_W'(ms_num_q) : ns_num_q;

	always_comb begin
		unique case (state_q)
			S_NUM_MS: begin
				div_dividend = COUNT_W'(MS_PER_SEC);
				div_divisor  = gcd_res;
			end
			S_NUM_NS: begin
				div_dividend = COUNT_W'(NS_PER_SEC);
				div_divisor  = gcd_res;
			end
			S_DEN_MS, S_DEN_NS: begin
				div_dividend = COUNT_W'(freq_q);
				div_divisor  = gcd_res;
			end
			default: begin
				div_dividend = mul_prod;
				div_divisor  = is_ms ? ms_den_q : ns_den_q;
			end
		endcase
	end

	ttc_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch_q && (state_q == S_GCD_MS || state_q == S_GCD_NS)),
		.a_in   (gcd_a),
		.b_in   (freq_q),
		.done   (gcd_done),
		.gcd    (gcd_res)
	);

	ttc_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (launch_q && state_q == S_MUL),
		.multiplicand (ticks),
		.multiplier   (mul_num),
		.done         (mul_done),
		.product      (mul_prod),
		.overflow     (mul_ovf)
	);

	ttc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch_q && (state_q == S_NUM_MS || state_q == S_DEN_MS
			|| state_q == S_NUM_NS || state_q == S_DEN_NS || state_q == S_DIV)),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Frequency register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg_we) begin
			freq_q <= cfg_wdata;
		end
	end

	// Sequencer with the timer state it owns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			start_q  <= '0;
			ms_num_q <= '0;
			ms_den_q <= '0;
			ns_num_q <= '0;
			ns_den_q <= '0;
		end else begin
			launch_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_STOP) begin
							start_q <= '0;
							state_q <= S_OUT;
						end else if (start_q == '0) begin
							state_q  <= S_GCD_MS;
							launch_q <= 1'b1;
						end else if (kind == KIND_START) begin
							state_q <= S_OUT;
						end else begin
							state_q  <= S_MUL;
							launch_q <= 1'b1;
						end
					end
				end
				S_GCD_MS: begin
					if (gcd_done) begin
						state_q  <= S_NUM_MS;
						launch_q <= 1'b1;
					end
				end
				S_NUM_MS: begin
					if (div_done) begin
						ms_num_q <= div_quo[MS_NUM_W-1:0];
						state_q  <= S_DEN_MS;
						launch_q <= 1'b1;
					end
				end
				S_DEN_MS: begin
					if (div_done) begin
						ms_den_q <= div_quo[FREQ_W-1:0];
						state_q  <= S_GCD_NS;
						launch_q <= 1'b1;
					end
				end
				S_GCD_NS: begin
					if (gcd_done) begin
						state_q  <= S_NUM_NS;
						launch_q <= 1'b1;
					end
				end
				S_NUM_NS: begin
					if (div_done) begin
						ns_num_q <= div_quo[NS_NUM_W-1:0];
						state_q  <= S_DEN_NS;
						launch_q <= 1'b1;
					end
				end
				S_DEN_NS: begin
					if (div_done) begin
						ns_den_q <= div_quo[FREQ_W-1:0];
						// A zero count is kept as all ones, since zero means not started.
						start_q  <= (count_q == '0) ? '1 : count_q;
						if (kind_q == KIND_START) begin
							state_q <= S_OUT;
						end else begin
							state_q  <= S_MUL;
							launch_q <= 1'b1;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q  <= S_DIV;
						launch_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item and result holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			count_q    <= counter_value;
			res_time_q <= '0;
			res_ovf_q  <= 1'b0;
		end else begin
			if (state_q == S_MUL && mul_done) begin
				res_ovf_q <= mul_ovf;
			end
			if (state_q == S_DIV && div_done) begin
				res_time_q <= div_quo;
			end
		end
	end

	// Output register: a beat stays until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_time_q <= res_time_q;
			out_ovf_q  <= res_ovf_q;
		end
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign elapsed_time     = out_time_q;
	assign product_overflow = out_ovf_q;

	// Checks on the sequencer.
	`TTC_ASSERT(a_out_load, (state_q == S_OUT && out_free) |=> out_valid_q,
		"result beat was not presented")
	`TTC_ASSERT(a_stop_clears, (accept && kind == KIND_STOP) |=> (start_q == '0),
		"stop did not clear the start count")
	`TTC_ASSERT(a_read_started, (state_q == S_MUL) |-> (start_q != '0),
		"product started without a start count")
	`TTC_NEVER(a_div_stray, div_done && (state_q == S_IDLE || state_q == S_OUT
		|| state_q == S_MUL || state_q == S_GCD_MS || state_q == S_GCD_NS),
		"divider finished outside a divide step")

endmodule

FILE: bench/timer_tick_to_time_converter_core_tb.sv
// ---------------------------------------------------------------------------
// Timer tick to time converter testbench
// Drives start, read and stop beats into the converter under random idling on
// both channels and checks every elapsed time and overflow flag against a
// behavioural predictor. Directed cases cover the reset frequency, the
// frequency extremes and the special start cases. Random sessions follow.
// ---------------------------------------------------------------------------
module timer_tick_to_time_converter_core_tb;
	import ttc_pkg::*;

	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     SETTLE_CYCLES  = 500;
	localparam int     RANDOM_ITEMS   = 1030;
	localparam count_t ALL_ONES       = '1;

	typedef struct packed {
		count_t elapsed;
		logic   ovf;
	} time_result_t;

	// Block ports; the driven inputs are all known from time zero.
	logic   clk           = 1'b0;
	logic   arst_n        = 1'b0;
	logic   cfg_we        = 1'b0;
	freq_t  cfg_wdata     = '0;
	logic   in_valid      = 1'b0;
	logic   in_stall;
	kind_t  kind          = KIND_START;
	count_t counter_value = '0;
	logic   out_valid;
	logic   out_stall     = 1'b0;
	count_t elapsed_time;
	logic   product_overflow;

	// Predictor state.
	freq_t                model_freq = FREQ_RESET;
	count_t               start_tick = '0;
	logic [MS_NUM_W-1:0]  ms_num = '0;
	freq_t                ms_den = '0;
	logic [NS_NUM_W-1:0]  ns_num = '0;
	freq_t                ns_den = '0;

	time_result_t expected_times[$];
	int           mismatch_count = 0;
	int           items_counted  = 0;
	int           quiet_cycles   = 0;
	int           stall_run      = 0;
	bit           sender_idle    = 1'b1;
	bit           recv_idle      = 1'b1;

	timer_tick_to_time_converter_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.counter_value    (counter_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.elapsed_time     (elapsed_time),
		.product_overflow (product_overflow)
	);

	always #6 clk = ~clk;

	// Greatest common divisor by repeated remainders.
	function automatic freq_t euclid_gcd(freq_t a, freq_t b);
		freq_t r;
		while (b != '0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// Expected result of one beat; updates the predictor state.
	// A start on a started timer leaves everything as it is.
	function automatic time_result_t convert_ticks(kind_t k, count_t c);
		time_result_t res;
		freq_t        g;
		count_t       num;
		count_t       den;
		count_t       ticks;
		res = '0;
		if (k == KIND_STOP) begin
			start_tick = '0;
		end else if (start_tick == '0) begin
			g = euclid_gcd(MS_PER_SEC, model_freq);
			ms_num = MS_NUM_W'(MS_PER_SEC / g);
			ms_den = model_freq / g;
			g = euclid_gcd(NS_PER_SEC, model_freq);
			ns_num = NS_NUM_W'(NS_PER_SEC / g);
			ns_den = model_freq / g;
			start_tick = (c == '0) ? ALL_ONES : c;
		end
		if (k == KIND_READ_MS || k == KIND_READ_NS) begin
			num = (k == KIND_READ_MS) ? count_t'(ms_num) : count_t'(ns_num);
			den = (k == KIND_READ_MS) ? count_t'(ms_den) : count_t'(ns_den);
			ticks = c - start_tick;
			res.elapsed = (den != '0) ? (ticks * num) / den : ALL_ONES;
			res.ovf = (num != '0) && (ticks > ALL_ONES / num);
		end
		return res;
	endfunction

	function automatic count_t random_count();
		return {$urandom, $urandom};
	endfunction

	// Sends one beat, optionally after an idle burst, and records its expectation.
	task automatic send_beat(kind_t k, count_t c);
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		counter_value <= c;
		do @(posedge clk); while (in_stall);
		expected_times.push_back(convert_ticks(k, c));
		items_counted++;
	endtask

	// Holds the sender off until every expected result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_times.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_freq_reg(freq_t f);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_freq = f;
	endtask

	// Reset frequency: start at count zero, repeated start, wrap-around and stop.
	task automatic test_reset_frequency();
		send_beat(KIND_READ_MS, '0);
		send_beat(KIND_READ_NS, count_t'(5));
		send_beat(KIND_START, count_t'(100));
		send_beat(KIND_READ_MS, ALL_ONES);
		send_beat(KIND_STOP, '0);
		send_beat(KIND_START, ALL_ONES);
		send_beat(KIND_READ_NS, count_t'(3));
		send_beat(KIND_STOP, ALL_ONES);
	endtask

	// Zero, one, largest and decimal frequencies, with a forced product overflow.
	task automatic test_frequency_extremes();
		write_freq_reg('0);
		send_beat(KIND_READ_MS, count_t'(10));
		send_beat(KIND_READ_NS, count_t'(20));
		send_beat(KIND_STOP, '0);
		write_freq_reg(freq_t'(1));
		send_beat(KIND_START, count_t'(1));
		send_beat(KIND_READ_NS, 64'h8000_0000_0000_0000);
		send_beat(KIND_READ_MS, ALL_ONES);
		send_beat(KIND_STOP, '0);
		write_freq_reg('1);
		send_beat(KIND_READ_NS, count_t'(1));
		send_beat(KIND_READ_MS, 64'h5555_AAAA_5555_AAAA);
		send_beat(KIND_STOP, '0);
		write_freq_reg(freq_t'(1000));
		send_beat(KIND_START, count_t'(123));
		send_beat(KIND_READ_MS, 64'h0000_0000_0001_0000);
		send_beat(KIND_STOP, '0);
	endtask

	// Sessions of start, reads and stop at random frequencies, with some noise.
	task automatic test_random_sessions();
		freq_t  f;
		count_t base;
		count_t delta;
		kind_t  rd;
		int     n;
		while (items_counted < RANDOM_ITEMS) begin
			sender_idle = (items_counted < RANDOM_ITEMS - 80) && ($urandom_range(0, 3) != 0);
			recv_idle   = sender_idle;
			case ($urandom_range(0, 15))
				0:       f = '0;
				1:       f = '1;
				2:       f = freq_t'(1);
				3:       f = FREQ_RESET;
				4, 5:    f = freq_t'($urandom_range(1, 1000));
				6, 7:    f = freq_t'(1000 * $urandom_range(1, 4000000));
				default: f = freq_t'($urandom);
			endcase
			write_freq_reg(f);
			case ($urandom_range(0, 7))
				0:       base = '0;
				1:       base = ALL_ONES - count_t'($urandom_range(0, 1000));
				default: base = random_count();
			endcase
			rd = ($urandom_range(0, 1) != 0) ? KIND_READ_MS : KIND_READ_NS;
			send_beat(($urandom_range(0, 1) != 0) ? KIND_START : rd, base);
			n = $urandom_range(3, 12);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0:       delta = count_t'($urandom_range(0, 1000));
					1:       delta = count_t'($urandom);
					2:       delta = {28'h0, 4'($urandom_range(0, 15)), 32'($urandom)};
					default: delta = random_count();
				endcase
				rd = ($urandom_range(0, 1) != 0) ? KIND_READ_MS : KIND_READ_NS;
				case ($urandom_range(0, 11))
					0:       send_beat(kind_t'($urandom_range(0, 3)), random_count());
					1:       send_beat(KIND_START, random_count());
					default: send_beat(rd, base + delta);
				endcase
			end
			if ($urandom_range(0, 9) != 0)
				send_beat(KIND_STOP, random_count());
		end
	endtask

	// Receiver stall in random bursts.
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else if (recv_idle && $urandom_range(0, 5) == 0) begin
			stall_run = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Each result beat is compared with the oldest expectation.
	always @(posedge clk) begin
		time_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_times.size() == 0) begin
				$error("unexpected result: elapsed_time %0h", elapsed_time);
				mismatch_count++;
			end else begin
				want = expected_times.pop_front();
				if (elapsed_time !== want.elapsed) begin
					$error("elapsed_time: expected %0h, actual %0h", want.elapsed, elapsed_time);
					mismatch_count++;
				end
				if (product_overflow !== want.ovf) begin
					$error("product_overflow: expected %0b, actual %0b", want.ovf,
						product_overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frequency();
		test_frequency_extremes();
		test_random_sessions();
		in_valid <= 1'b0;
		while (expected_times.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
